// ===== sv/tbpc_pkg.sv =====
// Package for the back posture classifier: widths, codes, level/twist encodings.
// No dependencies.
package tbpc_pkg;
	localparam int DIST_BITS  = 12;
	localparam int COUNT_BITS = 16;
	localparam int FRAC_BITS  = 4;
	localparam int NSENS      = 6;
	localparam int SUM_BITS   = 28;
	localparam int BASE_BITS  = 16;
	localparam int CFG_BITS   = 10;
	localparam int CIDX_BITS  = 3;
	// signed delta: dist<<F minus baseline
	localparam int DW         = DIST_BITS + FRAC_BITS + 2;
	localparam int NUM_BITS   = SUM_BITS + FRAC_BITS;
	localparam int PRESENCE_MAX = 500;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0, OP_CAL = 2'd1, OP_FINAL = 2'd2, OP_CLASSIFY = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_UC_EPS = 3'd0, CFG_LC_EPS = 3'd1, CFG_U_SL = 3'd2, CFG_L_SL = 3'd3,
		CFG_U_MD = 3'd4, CFG_L_MD = 3'd5, CFG_ASYM = 3'd6, CFG_TILT = 3'd7
	} cfg_idx_t;

	localparam logic [2:0] LVL_UNKNOWN = 3'd0;
	localparam logic [2:0] LVL_CONTACT = 3'd1;
	localparam logic [2:0] LVL_SLIGHT  = 3'd2;
	localparam logic [2:0] LVL_MEDIUM  = 3'd3;
	localparam logic [2:0] LVL_FAR     = 3'd4;
	localparam logic [1:0] TW_NONE  = 2'd0;
	localparam logic [1:0] TW_LEFT  = 2'd1;
	localparam logic [1:0] TW_RIGHT = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  valid_mask;
		logic [DIST_BITS-1:0] dist_0, dist_1, dist_2, dist_3, dist_4, dist_5;
	} in_item_t;

	typedef struct packed {
		logic       tags_valid, back_in_range, torso_forward, torso_backward;
		logic       contact_all, neutral;
		logic [2:0] upper_level, middle_level, lower_level;
		logic [1:0] upper_twist, middle_twist, lower_twist;
	} out_item_t;

	// thresholds seen by one row lane
	typedef struct packed {
		logic [CFG_BITS-1:0] eps, sl, md, asym;
	} row_cfg_t;

	typedef struct packed {
		logic [2:0] lvl;
		logic [1:0] tw;
		logic       known;
		logic       asym;
	} row_res_t;
endpackage

// ===== sv/tbpc_if.sv =====
// Valid/ready channel interfaces for input, output and configuration.
// Depends on tbpc_pkg.
interface tbpc_in_if import tbpc_pkg::*; ();
	logic     valid, ready;
	in_item_t data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

interface tbpc_out_if import tbpc_pkg::*; ();
	logic      valid, ready;
	out_item_t data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

interface tbpc_cfg_if import tbpc_pkg::*; ();
	logic                 valid, ready;
	logic [CIDX_BITS-1:0] index;
	logic [CFG_BITS-1:0]  wdata;
	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

// ===== sv/tbpc_divider.sv =====
// Restoring serial divider: one quotient bit per cycle for the baseline mean.
// Depends on tbpc_pkg.
module tbpc_divider import tbpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NUM_BITS-1:0]   num,
	input  logic [COUNT_BITS-1:0] den,
	output logic                  busy,
	output logic [BASE_BITS-1:0]  quot
);
	localparam int CB = $clog2(NUM_BITS + 1);
	logic [NUM_BITS-1:0]   q_q;
	logic [COUNT_BITS:0]   rem_q;
	logic [COUNT_BITS-1:0] den_q;
	logic [CB-1:0]         cnt_q;
	logic [COUNT_BITS+1:0] trial;

	assign trial = {rem_q, q_q[NUM_BITS-1]} - {2'b00, den_q};
	assign busy  = cnt_q != '0;
	assign quot  = q_q[BASE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CB'(NUM_BITS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			if (!trial[COUNT_BITS+1]) begin
				rem_q <= trial[COUNT_BITS:0];
				q_q   <= {q_q[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[COUNT_BITS-1:0], q_q[NUM_BITS-1]};
				q_q   <= {q_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== sv/tbpc_row_lane.sv =====
// One row lane: level from the summed pair delta and left/right twist.
// Depends on tbpc_pkg.
module tbpc_row_lane import tbpc_pkg::*; (
	input  logic                 hl,
	input  logic                 hr,
	input  logic signed [DW-1:0] dl,
	input  logic signed [DW-1:0] dr,
	input  row_cfg_t             cfg,
	output row_res_t             res
);
	logic signed [DW:0]   m2, diff, ad;
	logic signed [DW+1:0] te, ts, tm, ta;

	always_comb begin
		if (hl && hr) m2 = (DW+1)'(dl) + (DW+1)'(dr);
		else if (hl)  m2 = (DW+1)'(dl) <<< 1;
		else          m2 = (DW+1)'(dr) <<< 1;
		diff = (DW+1)'(dl) - (DW+1)'(dr);
		ad   = diff[DW] ? -diff : diff;
		te = (DW+2)'({1'b0, cfg.eps}) <<< (FRAC_BITS + 1);
		ts = (DW+2)'({1'b0, cfg.sl}) <<< (FRAC_BITS + 1);
		tm = (DW+2)'({1'b0, cfg.md}) <<< (FRAC_BITS + 1);
		ta = (DW+2)'({1'b0, cfg.asym}) <<< FRAC_BITS;
		res.known = hl || hr;
		res.asym  = 1'b0;
		res.tw    = TW_NONE;
		if (!res.known)                res.lvl = LVL_UNKNOWN;
		else if ((DW+2)'(m2) <= te)    res.lvl = LVL_CONTACT;
		else if ((DW+2)'(m2) <= ts)    res.lvl = LVL_SLIGHT;
		else if ((DW+2)'(m2) <= tm)    res.lvl = LVL_MEDIUM;
		else                           res.lvl = LVL_FAR;
		if (hl && hr && (DW+2)'(ad) >= ta) begin
			res.asym = 1'b1;
			res.tw   = (diff > 0) ? TW_RIGHT : TW_LEFT;
		end
	end
endmodule

// ===== sv/tbpc_merge.sv =====
// Merging stage: presence and tilt from the frame, contact_all and neutral from the three lanes.
// Depends on tbpc_pkg.
module tbpc_merge import tbpc_pkg::*; (
	input  logic [5:0]                 mask,
	input  logic [NSENS*DIST_BITS-1:0] dists,
	input  logic signed [DW+2:0]       dsum,
	input  logic [CFG_BITS-1:0]        tilt_mm,
	input  row_res_t                   rr [3],
	output out_item_t                  res
);
	logic [2:0]            present, nvalid;
	logic                  in_range, any_known, any_asym;
	logic signed [DW+2:0]  tilt;
	logic [2:0]            minr, maxr;
	logic [DIST_BITS-1:0]  d;

	always_comb begin
		present = '0;
		nvalid  = '0;
		for (int i = 0; i < NSENS; i++) begin
			d = dists[i*DIST_BITS +: DIST_BITS];
			if (mask[i]) begin
				nvalid = nvalid + 3'd1;
				if (d != '0 && 32'(d) < PRESENCE_MAX) present = present + 3'd1;
			end
		end
		in_range = present >= 3'd2;
		tilt = ((DW+3)'(tilt_mm) << FRAC_BITS) * (DW+3)'(nvalid);
		minr = LVL_FAR;
		maxr = LVL_UNKNOWN;
		any_known = 1'b0;
		any_asym  = 1'b0;
		for (int r = 0; r < 3; r++) begin
			if (rr[r].known) begin
				any_known = 1'b1;
				if (rr[r].lvl < minr) minr = rr[r].lvl;
				if (rr[r].lvl > maxr) maxr = rr[r].lvl;
			end
			any_asym = any_asym | rr[r].asym;
		end
		res = '0;
		res.tags_valid     = 1'b1;
		res.back_in_range  = in_range;
		res.torso_forward  = in_range && nvalid != '0 && dsum > tilt;
		res.torso_backward = in_range && nvalid != '0 && dsum < -tilt;
		res.contact_all    = rr[0].lvl == LVL_CONTACT && rr[1].lvl == LVL_CONTACT
			&& rr[2].lvl == LVL_CONTACT;
		res.neutral = in_range && any_known && !any_asym && (maxr - minr) <= 3'd1;
		res.upper_level  = rr[0].lvl;
		res.middle_level = rr[1].lvl;
		res.lower_level  = rr[2].lvl;
		res.upper_twist  = rr[0].tw;
		res.middle_twist = rr[1].tw;
		res.lower_twist  = rr[2].tw;
	end
endmodule

// ===== sv/tof_back_posture_classifier_core.sv =====
// Channel  | dir  | payload
// inp      | in   | operation, valid_mask, dist_0..dist_5
// outp     | out  | twelve tag fields, one request per classify
// cfg      | in   | index (3b), wdata (10b)
// Classify: accepted, result registered next cycle; three row lanes and a merge are combinational.
// Calibrate: up to 6 serial divisions (one per sensor with samples) through one shared divider.
// Clear/finalize take effect when accepted. A pending result blocks further input until taken.
// Reset clears state, counts, sums and baseline; thresholds return to defaults.
// Depends on tbpc_pkg, tbpc_if, tbpc_divider, tbpc_row_lane, tbpc_merge.
module tof_back_posture_classifier_core import tbpc_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	tbpc_in_if.sink     inp,
	tbpc_out_if.source  outp,
	tbpc_cfg_if.sink    cfg
);
	typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_OUT} state_t;
	state_t state_q;
	logic [SUM_BITS-1:0]   sum_q   [NSENS];
	logic [COUNT_BITS-1:0] cnt_q   [NSENS];
	logic [BASE_BITS-1:0]  base_q  [NSENS];
	logic                  armed_q;
	logic [2:0]            sidx_q;
	logic [CFG_BITS-1:0]   creg_q  [8];
	out_item_t             res_q;
	logic                  div_start, div_busy;
	logic [BASE_BITS-1:0]  div_quot;
	logic [NUM_BITS-1:0]   div_num;
	logic [DIST_BITS-1:0]  sdist  [NSENS];
	logic signed [DW-1:0]  delta  [NSENS];
	logic signed [DW+2:0]  dsum;
	row_res_t              rr     [3];
	row_cfg_t              rcfg   [3];
	out_item_t             mres;
	logic                  acc;

	assign sdist[0] = inp.data.dist_0;
	assign sdist[1] = inp.data.dist_1;
	assign sdist[2] = inp.data.dist_2;
	assign sdist[3] = inp.data.dist_3;
	assign sdist[4] = inp.data.dist_4;
	assign sdist[5] = inp.data.dist_5;

	assign inp.ready  = state_q == S_IDLE;
	assign cfg.ready  = 1'b1;
	assign outp.valid = state_q == S_OUT;
	assign outp.data  = res_q;
	assign acc = inp.valid && inp.ready;

	always_comb begin
		dsum = '0;
		for (int i = 0; i < NSENS; i++) begin
			delta[i] = DW'({2'b00, sdist[i], FRAC_BITS'(0)}) - DW'({2'b00, base_q[i]});
			if (inp.data.valid_mask[i]) dsum = dsum + (DW+3)'(delta[i]);
		end
	end

	assign rcfg[0] = {creg_q[CFG_UC_EPS], creg_q[CFG_U_SL], creg_q[CFG_U_MD], creg_q[CFG_ASYM]};
	assign rcfg[1] = rcfg[0];
	assign rcfg[2] = {creg_q[CFG_LC_EPS], creg_q[CFG_L_SL], creg_q[CFG_L_MD], creg_q[CFG_ASYM]};

	tbpc_row_lane u_upper (.hl(inp.data.valid_mask[0]), .hr(inp.data.valid_mask[3]),
		.dl(delta[0]), .dr(delta[3]), .cfg(rcfg[0]), .res(rr[0]));
	tbpc_row_lane u_middle (.hl(inp.data.valid_mask[2]), .hr(inp.data.valid_mask[5]),
		.dl(delta[2]), .dr(delta[5]), .cfg(rcfg[1]), .res(rr[1]));
	tbpc_row_lane u_lower (.hl(inp.data.valid_mask[1]), .hr(inp.data.valid_mask[4]),
		.dl(delta[1]), .dr(delta[4]), .cfg(rcfg[2]), .res(rr[2]));

	tbpc_merge u_merge (.mask(inp.data.valid_mask),
		.dists({sdist[5], sdist[4], sdist[3], sdist[2], sdist[1], sdist[0]}),
		.dsum(dsum), .tilt_mm(creg_q[CFG_TILT]), .rr(rr), .res(mres));

	assign div_start = state_q == S_START && cnt_q[sidx_q] != '0;
	assign div_num = {sum_q[sidx_q], FRAC_BITS'(0)} + NUM_BITS'(cnt_q[sidx_q] >> 1);

	tbpc_divider u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(cnt_q[sidx_q]), .busy(div_busy), .quot(div_quot));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			armed_q <= 1'b0;
			sidx_q  <= '0;
			res_q   <= '0;
			for (int i = 0; i < NSENS; i++) begin
				sum_q[i] <= '0; cnt_q[i] <= '0; base_q[i] <= '0;
			end
			creg_q[CFG_UC_EPS] <= 10'd20;  creg_q[CFG_LC_EPS] <= 10'd30;
			creg_q[CFG_U_SL]   <= 10'd60;  creg_q[CFG_L_SL]   <= 10'd70;
			creg_q[CFG_U_MD]   <= 10'd120; creg_q[CFG_L_MD]   <= 10'd130;
			creg_q[CFG_ASYM]   <= 10'd15;  creg_q[CFG_TILT]   <= 10'd30;
		end else begin
			if (cfg.valid) creg_q[cfg.index] <= cfg.wdata;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (op_t'(inp.data.operation))
							OP_CLEAR: begin
								armed_q <= 1'b0;
								for (int i = 0; i < NSENS; i++) begin
									sum_q[i] <= '0; cnt_q[i] <= '0; base_q[i] <= '0;
								end
							end
							OP_CAL: begin
								for (int i = 0; i < NSENS; i++)
									if (inp.data.valid_mask[i] && cnt_q[i] != '1) begin
										sum_q[i] <= sum_q[i] + SUM_BITS'(sdist[i]);
										cnt_q[i] <= cnt_q[i] + 1'b1;
									end
								sidx_q  <= '0;
								state_q <= S_START;
							end
							OP_FINAL: armed_q <= 1'b1;
							OP_CLASSIFY: begin
								res_q   <= armed_q ? mres : '0;
								state_q <= S_OUT;
							end
							default: ;
						endcase
					end
				end
				S_START: begin
					if (cnt_q[sidx_q] == '0) begin
						base_q[sidx_q] <= '0;
						if (sidx_q == 3'(NSENS-1)) state_q <= S_IDLE;
						else sidx_q <= sidx_q + 1'b1;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (!div_busy) begin
						base_q[sidx_q] <= div_quot;
						if (sidx_q == 3'(NSENS-1)) state_q <= S_IDLE;
						else begin
							sidx_q  <= sidx_q + 1'b1;
							state_q <= S_START;
						end
					end
				end
				S_OUT: if (outp.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !acc) else $error("accepted while busy");
	a_unarmed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		outp.valid && !res_q.tags_valid |-> res_q == '0) else $error("unarmed result not zero");
	a_div_only_cal: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == S_WAIT) else $error("divider busy outside calibrate");
	a_tilt_excl: assert property (@(posedge clk) disable iff (!arst_n)
		outp.valid |-> !(res_q.torso_forward && res_q.torso_backward))
		else $error("both tilts");
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the back posture classifier core.
// Drives frames and register writes, predicts tags per classify request.
// Depends on tbpc_pkg, tbpc_if and the core.
`timescale 1ns / 1ps
module testbench;
	import tbpc_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	tbpc_in_if  inp ();
	tbpc_out_if outp ();
	tbpc_cfg_if cfg ();

	tof_back_posture_classifier_core DUT (
		.clk(clk), .arst_n(arst_n), .inp(inp), .outp(outp), .cfg(cfg)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// predictor state
	logic [SUM_BITS-1:0]   p_sum   [NSENS];
	logic [COUNT_BITS-1:0] p_cnt   [NSENS];
	logic [BASE_BITS-1:0]  p_base  [NSENS];
	logic                  p_armed;
	logic [CFG_BITS-1:0]   p_cfg   [8];

	in_item_t  frames_pending [$];
	out_item_t tags_expected [$];
	int errors = 0;
	int send_idle = 0, recv_stall = 0;
	longint cycles = 0;

	logic                 cfg_req;
	logic [CIDX_BITS-1:0] cfg_idx;
	logic [CFG_BITS-1:0]  cfg_val;

	function automatic logic [DIST_BITS-1:0] dist_of(in_item_t f, int i);
		case (i)
			0: return f.dist_0;
			1: return f.dist_1;
			2: return f.dist_2;
			3: return f.dist_3;
			4: return f.dist_4;
			default: return f.dist_5;
		endcase
	endfunction

	function automatic logic [2:0] row_level(longint m2, int row);
		longint eps, sl, md;
		eps = (row == 2) ? p_cfg[CFG_LC_EPS] : p_cfg[CFG_UC_EPS];
		sl  = (row == 2) ? p_cfg[CFG_L_SL] : p_cfg[CFG_U_SL];
		md  = (row == 2) ? p_cfg[CFG_L_MD] : p_cfg[CFG_U_MD];
		if (m2 <= (eps << (FRAC_BITS + 1))) return LVL_CONTACT;
		if (m2 <= (sl << (FRAC_BITS + 1))) return LVL_SLIGHT;
		if (m2 <= (md << (FRAC_BITS + 1))) return LVL_MEDIUM;
		return LVL_FAR;
	endfunction

	// updates state; returns 1 with tags when a classify yields a result
	function automatic bit predict_tags(in_item_t f, output out_item_t t);
		longint delta [NSENS];
		longint dsum, tilt, diff, ad, num;
		int present, nvalid, li, ri, minr, maxr;
		bit hl, hr, any_asym, any_known, in_rng;
		logic [2:0] lvl [3];
		logic [1:0] tw [3];
		int lefts [3], rights [3];
		lefts = '{0, 2, 1};
		rights = '{3, 5, 4};
		t = '0;
		case (op_t'(f.operation))
			OP_CLEAR: begin
				for (int i = 0; i < NSENS; i++) begin
					p_sum[i] = 0; p_cnt[i] = 0; p_base[i] = 0;
				end
				p_armed = 0;
				return 0;
			end
			OP_CAL: begin
				for (int i = 0; i < NSENS; i++) begin
					if (f.valid_mask[i] && p_cnt[i] != {COUNT_BITS{1'b1}}) begin
						p_sum[i] = p_sum[i] + SUM_BITS'(dist_of(f, i));
						p_cnt[i] = p_cnt[i] + 1'b1;
					end
					if (p_cnt[i] != 0) begin
						num = (longint'(p_sum[i]) << FRAC_BITS) + longint'(p_cnt[i] >> 1);
						p_base[i] = BASE_BITS'(num / longint'(p_cnt[i]));
					end else
						p_base[i] = 0;
				end
				return 0;
			end
			OP_FINAL: begin
				p_armed = 1;
				return 0;
			end
			default: ;
		endcase
		if (!p_armed) return 1;
		t.tags_valid = 1;
		present = 0; nvalid = 0; dsum = 0;
		for (int i = 0; i < NSENS; i++) begin
			delta[i] = (longint'(dist_of(f, i)) << FRAC_BITS) - longint'(p_base[i]);
			if (f.valid_mask[i]) begin
				nvalid++;
				dsum += delta[i];
				if (dist_of(f, i) > 0 && dist_of(f, i) < PRESENCE_MAX) present++;
			end
		end
		in_rng = present >= 2;
		t.back_in_range = in_rng;
		tilt = (longint'(p_cfg[CFG_TILT]) << FRAC_BITS) * nvalid;
		if (in_rng && nvalid > 0) begin
			t.torso_forward = dsum > tilt;
			t.torso_backward = dsum < -tilt;
		end
		any_asym = 0; any_known = 0; minr = 4; maxr = 0;
		for (int r = 0; r < 3; r++) begin
			li = lefts[r]; ri = rights[r];
			hl = f.valid_mask[li]; hr = f.valid_mask[ri];
			lvl[r] = LVL_UNKNOWN; tw[r] = TW_NONE;
			if (hl || hr) begin
				if (hl && hr) begin
					diff = delta[li] - delta[ri];
					ad = diff < 0 ? -diff : diff;
					lvl[r] = row_level(delta[li] + delta[ri], r);
					if (ad >= (longint'(p_cfg[CFG_ASYM]) << FRAC_BITS)) begin
						any_asym = 1;
						tw[r] = (diff > 0) ? TW_RIGHT : TW_LEFT;
					end
				end else
					lvl[r] = row_level(2 * (hl ? delta[li] : delta[ri]), r);
				any_known = 1;
				if (lvl[r] < minr) minr = lvl[r];
				if (lvl[r] > maxr) maxr = lvl[r];
			end
		end
		t.contact_all = lvl[0] == LVL_CONTACT && lvl[1] == LVL_CONTACT
			&& lvl[2] == LVL_CONTACT;
		t.neutral = in_rng && any_known && !any_asym && (maxr - minr) <= 1;
		t.upper_level = lvl[0]; t.middle_level = lvl[1]; t.lower_level = lvl[2];
		t.upper_twist = tw[0]; t.middle_twist = tw[1]; t.lower_twist = tw[2];
		return 1;
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inp.valid <= 0;
			inp.data <= '0;
		end else begin
			out_item_t t;
			if (inp.valid && inp.ready) begin
				if (predict_tags(inp.data, t)) tags_expected.push_back(t);
			end
			if (!inp.valid || inp.ready) begin
				if (frames_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
					inp.data <= frames_pending.pop_front();
					inp.valid <= 1;
				end else
					inp.valid <= 0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outp.ready <= 0;
		end else begin
			out_item_t e;
			cycles++;
			if (outp.valid && outp.ready) begin
				if (tags_expected.size() == 0) begin
					$display("%0t unexpected result %h", $time, outp.data);
					errors++;
				end else begin
					e = tags_expected.pop_front();
					if (outp.data !== e) begin
						$display("%0t mismatch expected %h actual %h", $time, e, outp.data);
						errors++;
					end
				end
			end
			outp.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// register write channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.valid <= 0;
			cfg.index <= '0;
			cfg.wdata <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				p_cfg[cfg.index] = cfg.wdata;
				cfg.valid <= 0;
				cfg_req = 0;
			end else if (cfg_req && !cfg.valid) begin
				cfg.valid <= 1;
				cfg.index <= cfg_idx;
				cfg.wdata <= cfg_val;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (cycles > 2000000) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic in_item_t rand_frame(op_t op, bit near);
		in_item_t f;
		f.operation = op;
		f.valid_mask = $urandom_range(9) < 6 ? 6'h3f : 6'($urandom);
		f.dist_0 = DIST_BITS'($urandom); f.dist_1 = DIST_BITS'($urandom);
		f.dist_2 = DIST_BITS'($urandom); f.dist_3 = DIST_BITS'($urandom);
		f.dist_4 = DIST_BITS'($urandom); f.dist_5 = DIST_BITS'($urandom);
		if (near) begin
			// around a typical seated distance, spread over the level bands
			f.dist_0 = DIST_BITS'(150 + $urandom_range(300));
			f.dist_1 = DIST_BITS'(f.dist_0 + $urandom_range(160) - 40);
			f.dist_2 = DIST_BITS'(f.dist_0 + $urandom_range(160) - 40);
			f.dist_3 = DIST_BITS'(f.dist_0 + $urandom_range(60) - 30);
			f.dist_4 = DIST_BITS'(f.dist_1 + $urandom_range(60) - 30);
			f.dist_5 = DIST_BITS'(f.dist_2 + $urandom_range(60) - 30);
		end
		return f;
	endfunction

	task automatic wait_drained();
		while (frames_pending.size() > 0 || inp.valid || tags_expected.size() > 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int val);
		cfg_idx = idx; cfg_val = CFG_BITS'(val); cfg_req = 1;
		while (cfg_req) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic push_op(op_t op, logic [5:0] m, int d);
		in_item_t f;
		f.operation = op; f.valid_mask = m;
		f.dist_0 = DIST_BITS'(d); f.dist_1 = DIST_BITS'(d); f.dist_2 = DIST_BITS'(d);
		f.dist_3 = DIST_BITS'(d); f.dist_4 = DIST_BITS'(d); f.dist_5 = DIST_BITS'(d);
		frames_pending.push_back(f);
	endtask

	task automatic random_session(int n);
		int ncal;
		in_item_t f;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(9) == 0) begin
				f = rand_frame(op_t'($urandom_range(3)), 0);
				frames_pending.push_back(f);
			end else begin
				push_op(OP_CLEAR, 6'h3f, 0);
				ncal = $urandom_range(4);
				for (int c = 0; c < ncal; c++) frames_pending.push_back(rand_frame(OP_CAL, 1));
				push_op(OP_FINAL, 6'h00, 0);
				for (int c = 0; c < 6; c++)
					frames_pending.push_back(rand_frame(OP_CLASSIFY, $urandom_range(4) != 0));
				k += ncal + 7;
			end
		end
	endtask

	initial begin
		int defaults [8];
		in_item_t f;
		defaults = '{20, 30, 60, 70, 120, 130, 15, 30};
		for (int i = 0; i < NSENS; i++) begin
			p_sum[i] = 0; p_cnt[i] = 0; p_base[i] = 0;
		end
		for (int i = 0; i < 8; i++) p_cfg[i] = CFG_BITS'(defaults[i]);
		p_armed = 0;
		cfg_req = 0; cfg_idx = '0; cfg_val = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(posedge clk);

		// directed: unarmed classify, finalize with no samples, extremes
		push_op(OP_CLASSIFY, 6'h3f, 100);
		push_op(OP_FINAL, 6'h00, 0);
		push_op(OP_CLASSIFY, 6'h3f, 0);
		push_op(OP_CLASSIFY, 6'h00, 4095);
		push_op(OP_CLASSIFY, 6'h3f, 4095);
		push_op(OP_CAL, 6'h3f, 4095);
		push_op(OP_CAL, 6'h15, 0);
		push_op(OP_CLASSIFY, 6'h3f, 4095);
		push_op(OP_CLASSIFY, 6'h09, 499);
		push_op(OP_CLASSIFY, 6'h24, 1);
		push_op(OP_CLEAR, 6'h00, 0);
		push_op(OP_CAL, 6'h3f, 300);
		push_op(OP_CAL, 6'h3f, 301);
		push_op(OP_FINAL, 6'h3f, 0);
		push_op(OP_CLASSIFY, 6'h3f, 300);
		push_op(OP_CLASSIFY, 6'h3f, 500);
		push_op(OP_CLASSIFY, 6'h3f, 200);
		push_op(OP_CLASSIFY, 6'h01, 330);
		f = rand_frame(OP_CLASSIFY, 0);
		f.valid_mask = 6'h3f; f.dist_0 = 300; f.dist_3 = 340;
		f.dist_2 = 340; f.dist_5 = 300; f.dist_1 = 300; f.dist_4 = 300;
		frames_pending.push_back(f);
		wait_drained();

		// zero thresholds: equal deltas flag twist left
		for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), 0);
		push_op(OP_CLASSIFY, 6'h3f, 300);
		push_op(OP_CLASSIFY, 6'h3f, 299);
		random_session(60);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			for (int i = 0; i < 8; i++)
				write_reg(cfg_idx_t'(i), ph == 3 ? 1023 : (ph == 0 ? defaults[i]
					: $urandom_range(ph == 1 ? 150 : 1023)));
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 64; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 64; end
				default: begin send_idle = 25; recv_stall = 25; end
			endcase
			random_session(200);
			wait_drained();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
